FILE: rtl/core/thsc_pkg.sv
// ----------------------------------------------------------------------------
// thsc_pkg
// Shared types and constants of the two-wire humidity sensor controller.
// ----------------------------------------------------------------------------
package thsc_pkg;

   // Transaction codes carried in the operation field
   typedef enum logic [2:0] {
      OP_RESET        = 3'd0,
      OP_STATUS_READ  = 3'd1,
      OP_STATUS_WRITE = 3'd2,
      OP_MEAS_TEMP    = 3'd3,
      OP_MEAS_HUMI    = 3'd4
   } op_type;

   // Configuration register indexes
   localparam logic [2:0] CSR_HALF_PERIOD  = 3'd0;
   localparam logic [2:0] CSR_WAIT_LIMIT   = 3'd1;
   localparam logic [2:0] CSR_CMD_TEMP     = 3'd2;
   localparam logic [2:0] CSR_CMD_HUMI     = 3'd3;
   localparam logic [2:0] CSR_CMD_ST_READ  = 3'd4;
   localparam logic [2:0] CSR_CMD_ST_WRITE = 3'd5;
   localparam logic [2:0] CSR_CMD_SOFT_RST = 3'd6;

   localparam int unsigned CSR_DATA_W = 27;

   // Register reset values
   localparam logic [15:0] HALF_PERIOD_RST = 16'd500;
   localparam logic [26:0] WAIT_LIMIT_RST  = 27'd72000000;
   localparam logic [7:0]  CMD_TEMP_RST    = 8'd3;
   localparam logic [7:0]  CMD_HUMI_RST    = 8'd5;
   localparam logic [7:0]  CMD_ST_READ_RST = 8'd7;
   localparam logic [7:0]  CMD_ST_WR_RST   = 8'd6;
   localparam logic [7:0]  CMD_SOFT_RST    = 8'd30;

   // Clocks sent with DATA high for a connection reset
   localparam logic [3:0] RESET_CLOCKS = 4'd9;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_CR_INIT  = 5'd1,
      PH_CR_HI    = 5'd2,
      PH_CR_LO    = 5'd3,
      PH_TS0      = 5'd4,
      PH_TS1      = 5'd5,
      PH_TS2      = 5'd6,
      PH_TS3      = 5'd7,
      PH_TS4      = 5'd8,
      PH_TS5      = 5'd9,
      PH_TS6      = 5'd10,
      PH_WB_DATA  = 5'd11,
      PH_WB_HI    = 5'd12,
      PH_WB_LO    = 5'd13,
      PH_WB_ACKHI = 5'd14,
      PH_WB_ACKLO = 5'd15,
      PH_WAIT     = 5'd16,
      PH_RB_HI    = 5'd17,
      PH_RB_LO    = 5'd18,
      PH_RB_ACKD  = 5'd19,
      PH_RB_ACKHI = 5'd20,
      PH_RB_ACKLO = 5'd21,
      PH_END      = 5'd22
   } phase_type;

   typedef struct packed {
      logic [15:0] half_period;
      logic [26:0] wait_limit;
      logic [7:0]  cmd_measure_temp;
      logic [7:0]  cmd_measure_humi;
      logic [7:0]  cmd_status_read;
      logic [7:0]  cmd_status_write;
      logic [7:0]  cmd_soft_reset;
   } cfg_type;

   typedef struct packed {
      logic       start_req;
      logic [2:0] operation;
      logic [7:0] write_value;
      logic       data_in;
   } req_type;

   typedef struct packed {
      logic        sck;
      logic        data_drive;
      logic        data_out;
      logic        busy_res;
      logic        done_res;
      logic [15:0] value;
      logic [7:0]  checksum;
      logic [1:0]  error_count;
   } rsp_type;

endpackage

FILE: rtl/core/thsc_req_if.sv
// ----------------------------------------------------------------------------
// thsc_req_if
// Tick channel into the controller: sampled DATA plus an optional request.
// ----------------------------------------------------------------------------
interface thsc_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [2:0] operation;
   logic [7:0] write_value;
   logic       data_in;

   modport source (output valid, output start_req, output operation,
                   output write_value, output data_in, input ready);
   modport sink (input valid, input start_req, input operation,
                 input write_value, input data_in, output ready);
endinterface

FILE: rtl/core/thsc_rsp_if.sv
// ----------------------------------------------------------------------------
// thsc_rsp_if
// Result channel of the controller: pin levels and transaction status.
// ----------------------------------------------------------------------------
interface thsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        sck;
   logic        data_drive;
   logic        data_out;
   logic        busy_res;
   logic        done_res;
   logic [15:0] value;
   logic [7:0]  checksum;
   logic [1:0]  error_count;

   modport source (output valid, output sck, output data_drive, output data_out,
                   output busy_res, output done_res, output value,
                   output checksum, output error_count, input ready);
   modport sink (input valid, input sck, input data_drive, input data_out,
                 input busy_res, input done_res, input value,
                 input checksum, input error_count, output ready);
endinterface

FILE: rtl/core/thsc_csr.sv
// ----------------------------------------------------------------------------
// thsc_csr
// Configuration registers, write only.
// ----------------------------------------------------------------------------
module thsc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [2:0]                      csr_index,
   input  logic [thsc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output thsc_pkg::cfg_type               cfg
);

   thsc_pkg::cfg_type cfg_ff;
   thsc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            thsc_pkg::CSR_HALF_PERIOD:  cfg_in.half_period      = csr_wdata[15:0];
            thsc_pkg::CSR_WAIT_LIMIT:   cfg_in.wait_limit       = csr_wdata[26:0];
            thsc_pkg::CSR_CMD_TEMP:     cfg_in.cmd_measure_temp = csr_wdata[7:0];
            thsc_pkg::CSR_CMD_HUMI:     cfg_in.cmd_measure_humi = csr_wdata[7:0];
            thsc_pkg::CSR_CMD_ST_READ:  cfg_in.cmd_status_read  = csr_wdata[7:0];
            thsc_pkg::CSR_CMD_ST_WRITE: cfg_in.cmd_status_write = csr_wdata[7:0];
            thsc_pkg::CSR_CMD_SOFT_RST: cfg_in.cmd_soft_reset   = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period      <= thsc_pkg::HALF_PERIOD_RST;
         cfg_ff.wait_limit       <= thsc_pkg::WAIT_LIMIT_RST;
         cfg_ff.cmd_measure_temp <= thsc_pkg::CMD_TEMP_RST;
         cfg_ff.cmd_measure_humi <= thsc_pkg::CMD_HUMI_RST;
         cfg_ff.cmd_status_read  <= thsc_pkg::CMD_ST_READ_RST;
         cfg_ff.cmd_status_write <= thsc_pkg::CMD_ST_WR_RST;
         cfg_ff.cmd_soft_reset   <= thsc_pkg::CMD_SOFT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/thsc_engine.sv
// ----------------------------------------------------------------------------
// thsc_engine
// Bus sequencer: advances one tick per step and produces that tick's pins.
// ----------------------------------------------------------------------------
module thsc_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  thsc_pkg::req_type req,
   input  thsc_pkg::cfg_type cfg,
   output thsc_pkg::rsp_type rsp
);

   thsc_pkg::phase_type phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [26:0] wait_ff, wait_in;
   logic [3:0]  bit_ff, bit_in;
   logic [1:0]  byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  hop_ff, hop_in;
   logic [7:0]  hwv_ff, hwv_in;
   logic [15:0] value_ff, value_in;
   logic [7:0]  csum_ff, csum_in;
   logic [1:0]  err_ff, err_in;
   logic        sck_ff, sck_in;
   logic        drv_ff, drv_in;
   logic        dout_ff, dout_in;

   // values after a possible request take-over
   logic                start;
   thsc_pkg::phase_type ph_act;
   logic [15:0]         tick_eff;
   logic [3:0]          bit_eff;
   logic [1:0]          byte_eff;
   logic [2:0]          hop_eff;
   logic                in_wait;
   logic                wait_go;
   logic                fire;
   logic                last_rd;
   logic [15:0]         reload;
   logic [3:0]          bit_inc;
   logic [7:0]          cmd_byte;
   logic [1:0]          err_sat;

   assign start    = (phase_ff == thsc_pkg::PH_IDLE) && req.start_req &&
                     (req.operation <= thsc_pkg::OP_MEAS_HUMI);
   assign hop_eff  = start ? req.operation : hop_ff;
   assign tick_eff = start ? 16'd0 : tick_ff;
   assign bit_eff  = start ? 4'd0 : bit_ff;
   assign byte_eff = start ? 2'd0 : byte_ff;
   assign ph_act   = !start ? phase_ff :
                     (req.operation == thsc_pkg::OP_RESET) ? thsc_pkg::PH_CR_INIT
                                                           : thsc_pkg::PH_TS0;

   assign in_wait = (ph_act == thsc_pkg::PH_WAIT);
   assign wait_go = in_wait && (!req.data_in || (wait_ff >= cfg.wait_limit));
   assign fire    = !in_wait && (ph_act != thsc_pkg::PH_IDLE) && (tick_eff == 16'd0);
   assign last_rd = (hop_eff == thsc_pkg::OP_STATUS_READ) ? (byte_eff >= 2'd1)
                                                          : (byte_eff >= 2'd2);
   assign reload  = (cfg.half_period == 16'd0) ? 16'd0 : cfg.half_period - 16'd1;
   assign bit_inc = bit_eff + 4'd1;
   assign err_sat = (err_ff == 2'd3) ? 2'd3 : err_ff + 2'd1;

   always_comb begin
      case (hop_eff)
         thsc_pkg::OP_RESET:        cmd_byte = cfg.cmd_soft_reset;
         thsc_pkg::OP_STATUS_READ:  cmd_byte = cfg.cmd_status_read;
         thsc_pkg::OP_STATUS_WRITE: cmd_byte = cfg.cmd_status_write;
         thsc_pkg::OP_MEAS_TEMP:    cmd_byte = cfg.cmd_measure_temp;
         default:                   cmd_byte = cfg.cmd_measure_humi;
      endcase
   end

   // next phase
   always_comb begin
      phase_in = ph_act;
      if (in_wait) begin
         if (wait_go) begin
            phase_in = thsc_pkg::PH_RB_HI;
         end
      end else if (fire) begin
         case (ph_act)
            thsc_pkg::PH_CR_INIT:  phase_in = thsc_pkg::PH_CR_HI;
            thsc_pkg::PH_CR_HI:    phase_in = thsc_pkg::PH_CR_LO;
            thsc_pkg::PH_CR_LO:    phase_in = (bit_inc >= thsc_pkg::RESET_CLOCKS) ?
                                              thsc_pkg::PH_TS0 : thsc_pkg::PH_CR_HI;
            thsc_pkg::PH_TS0:      phase_in = thsc_pkg::PH_TS1;
            thsc_pkg::PH_TS1:      phase_in = thsc_pkg::PH_TS2;
            thsc_pkg::PH_TS2:      phase_in = thsc_pkg::PH_TS3;
            thsc_pkg::PH_TS3:      phase_in = thsc_pkg::PH_TS4;
            thsc_pkg::PH_TS4:      phase_in = thsc_pkg::PH_TS5;
            thsc_pkg::PH_TS5:      phase_in = thsc_pkg::PH_TS6;
            thsc_pkg::PH_TS6:      phase_in = thsc_pkg::PH_WB_DATA;
            thsc_pkg::PH_WB_DATA:  phase_in = thsc_pkg::PH_WB_HI;
            thsc_pkg::PH_WB_HI:    phase_in = thsc_pkg::PH_WB_LO;
            thsc_pkg::PH_WB_LO:    phase_in = (bit_eff == 4'd0) ?
                                              thsc_pkg::PH_WB_ACKHI : thsc_pkg::PH_WB_DATA;
            thsc_pkg::PH_WB_ACKHI: phase_in = thsc_pkg::PH_WB_ACKLO;
            thsc_pkg::PH_WB_ACKLO: begin
               if (hop_eff == thsc_pkg::OP_RESET) begin
                  phase_in = thsc_pkg::PH_END;
               end else if (hop_eff == thsc_pkg::OP_STATUS_WRITE) begin
                  phase_in = (byte_eff == 2'd0) ? thsc_pkg::PH_WB_DATA : thsc_pkg::PH_END;
               end else if (hop_eff == thsc_pkg::OP_STATUS_READ) begin
                  phase_in = thsc_pkg::PH_RB_HI;
               end else begin
                  phase_in = thsc_pkg::PH_WAIT;
               end
            end
            thsc_pkg::PH_RB_HI:    phase_in = thsc_pkg::PH_RB_LO;
            thsc_pkg::PH_RB_LO:    phase_in = (bit_eff == 4'd0) ?
                                              thsc_pkg::PH_RB_ACKD : thsc_pkg::PH_RB_HI;
            thsc_pkg::PH_RB_ACKD:  phase_in = thsc_pkg::PH_RB_ACKHI;
            thsc_pkg::PH_RB_ACKHI: phase_in = thsc_pkg::PH_RB_ACKLO;
            thsc_pkg::PH_RB_ACKLO: phase_in = last_rd ? thsc_pkg::PH_END : thsc_pkg::PH_RB_HI;
            default:               phase_in = thsc_pkg::PH_IDLE;
         endcase
      end
   end

   // datapath and pins
   always_comb begin
      tick_in  = tick_eff;
      wait_in  = wait_ff;
      bit_in   = bit_eff;
      byte_in  = byte_eff;
      shift_in = shift_ff;
      hop_in   = hop_eff;
      hwv_in   = start ? req.write_value : hwv_ff;
      value_in = start ? 16'd0 : value_ff;
      csum_in  = start ? 8'd0 : csum_ff;
      err_in   = start ? 2'd0 : err_ff;
      sck_in   = sck_ff;
      drv_in   = drv_ff;
      dout_in  = dout_ff;

      if (in_wait) begin
         if (wait_go) begin
            if (req.data_in) begin
               err_in = err_sat;   // timed out
            end
            tick_in  = reload;
            bit_in   = 4'd7;
            byte_in  = 2'd0;
            shift_in = 8'd0;
         end else begin
            wait_in = wait_ff + 27'd1;
         end
      end else if (ph_act != thsc_pkg::PH_IDLE && !fire) begin
         tick_in = tick_eff - 16'd1;
      end else if (fire) begin
         tick_in = reload;
         case (ph_act)
            thsc_pkg::PH_CR_INIT: begin
               drv_in  = 1'b1;
               dout_in = 1'b1;
               sck_in  = 1'b0;
               bit_in  = 4'd0;
            end
            thsc_pkg::PH_CR_HI: sck_in = 1'b1;
            thsc_pkg::PH_CR_LO: begin
               sck_in = 1'b0;
               bit_in = bit_inc;
            end
            thsc_pkg::PH_TS0: begin
               drv_in  = 1'b1;
               dout_in = 1'b1;
               sck_in  = 1'b0;
            end
            thsc_pkg::PH_TS1: sck_in = 1'b1;
            thsc_pkg::PH_TS2: begin
               drv_in  = 1'b1;
               dout_in = 1'b0;
            end
            thsc_pkg::PH_TS3: sck_in = 1'b0;
            thsc_pkg::PH_TS4: sck_in = 1'b1;
            thsc_pkg::PH_TS5: begin
               drv_in  = 1'b1;
               dout_in = 1'b1;
            end
            thsc_pkg::PH_TS6: begin
               sck_in   = 1'b0;
               shift_in = cmd_byte;
               bit_in   = 4'd7;
               byte_in  = 2'd0;
            end
            thsc_pkg::PH_WB_DATA: begin
               drv_in  = 1'b1;
               dout_in = shift_ff[bit_eff[2:0]];
            end
            thsc_pkg::PH_WB_HI: sck_in = 1'b1;
            thsc_pkg::PH_WB_LO: begin
               sck_in = 1'b0;
               if (bit_eff != 4'd0) begin
                  bit_in = bit_eff - 4'd1;
               end
            end
            thsc_pkg::PH_WB_ACKHI: begin
               drv_in  = 1'b0;
               dout_in = 1'b0;
               sck_in  = 1'b1;
            end
            thsc_pkg::PH_WB_ACKLO: begin
               if (req.data_in) begin
                  err_in = err_sat;   // no ack
               end
               sck_in = 1'b0;
               if (hop_eff == thsc_pkg::OP_STATUS_WRITE) begin
                  if (byte_eff == 2'd0) begin
                     byte_in  = 2'd1;
                     shift_in = hwv_ff;
                     bit_in   = 4'd7;
                  end
               end else if (hop_eff == thsc_pkg::OP_STATUS_READ) begin
                  bit_in   = 4'd7;
                  byte_in  = 2'd0;
                  shift_in = 8'd0;
               end else if (hop_eff != thsc_pkg::OP_RESET) begin
                  wait_in = 27'd0;
               end
            end
            thsc_pkg::PH_RB_HI: begin
               drv_in  = 1'b0;
               dout_in = 1'b0;
               sck_in  = 1'b1;
            end
            thsc_pkg::PH_RB_LO: begin
               shift_in = {shift_ff[6:0], req.data_in};
               sck_in   = 1'b0;
               if (bit_eff != 4'd0) begin
                  bit_in = bit_eff - 4'd1;
               end
            end
            thsc_pkg::PH_RB_ACKD: begin
               if (hop_eff == thsc_pkg::OP_STATUS_READ) begin
                  if (byte_eff == 2'd0) begin
                     value_in = {8'd0, shift_ff};
                  end else begin
                     csum_in = shift_ff;
                  end
               end else if (byte_eff == 2'd0) begin
                  value_in = {shift_ff, value_ff[7:0]};
               end else if (byte_eff == 2'd1) begin
                  value_in = {value_ff[15:8], shift_ff};
               end else begin
                  csum_in = shift_ff;
               end
               // ack low on data bytes, high (no ack) on the last byte
               drv_in  = 1'b1;
               dout_in = last_rd;
            end
            thsc_pkg::PH_RB_ACKHI: sck_in = 1'b1;
            thsc_pkg::PH_RB_ACKLO: begin
               sck_in = 1'b0;
               if (!last_rd) begin
                  byte_in  = byte_eff + 2'd1;
                  bit_in   = 4'd7;
                  shift_in = 8'd0;
               end
            end
            default: tick_in = 16'd0;   // end of transaction
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= thsc_pkg::PH_IDLE;
         tick_ff  <= '0;
         wait_ff  <= '0;
         bit_ff   <= '0;
         byte_ff  <= '0;
         shift_ff <= '0;
         hop_ff   <= '0;
         hwv_ff   <= '0;
         value_ff <= '0;
         csum_ff  <= '0;
         err_ff   <= '0;
         sck_ff   <= 1'b0;
         drv_ff   <= 1'b1;
         dout_ff  <= 1'b1;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         wait_ff  <= wait_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         hop_ff   <= hop_in;
         hwv_ff   <= hwv_in;
         value_ff <= value_in;
         csum_ff  <= csum_in;
         err_ff   <= err_in;
         sck_ff   <= sck_in;
         drv_ff   <= drv_in;
         dout_ff  <= dout_in;
      end
   end

   logic done;
   assign done = fire && (ph_act == thsc_pkg::PH_END);

   assign rsp.sck         = sck_in;
   assign rsp.data_drive  = drv_in;
   assign rsp.data_out    = dout_in;
   assign rsp.busy_res    = (phase_in != thsc_pkg::PH_IDLE);
   assign rsp.done_res    = done;
   assign rsp.value       = done ? value_in : 16'd0;
   assign rsp.checksum    = done ? csum_in : 8'd0;
   assign rsp.error_count = done ? err_in : 2'd0;

endmodule

FILE: rtl/core/two_wire_humidity_sensor_controller.sv
// ----------------------------------------------------------------------------
// two_wire_humidity_sensor_controller
// Bus master for a two-wire humidity/temperature sensor, one tick per beat.
// ----------------------------------------------------------------------------
// Path: an accepted req beat passes through the input register, then the
//   sequencer logic into the result register, which drives its rsp beat.
// Throughput: one tick beat per cycle while rsp is ready; set by the sequencer step.
// Reset: synchronous; sequencer idle, SCK low, DATA driven high, registers at
//   their documented defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
module two_wire_humidity_sensor_controller (
   input  logic                            clock,
   input  logic                            reset,
   thsc_req_if.sink                        req_chan,
   thsc_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [2:0]                      csr_index,
   input  logic [thsc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   thsc_pkg::cfg_type cfg;
   thsc_pkg::rsp_type step_rsp;

   // Input register: one tick beat waiting for the sequencer.
   logic              in_valid_ff, in_valid_in;
   thsc_pkg::req_type in_data_ff, in_data_in;

   // Result register: one tick's pin levels and status.
   logic              rsp_valid_ff, rsp_valid_in;
   thsc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_take;
   logic advance;   // sequencer consumes the held beat this cycle

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   // A new beat is taken whenever the input register is empty or empties this cycle,
   // so the stream keeps moving at one beat a cycle with rsp draining.
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in           = 1'b1;
         in_data_in.start_req  = req_chan.start_req;
         in_data_in.operation  = req_chan.operation;
         in_data_in.write_value = req_chan.write_value;
         in_data_in.data_in    = req_chan.data_in;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_rsp;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   thsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer state moves only when a beat passes into the result register.
   thsc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .cfg   (cfg),
      .rsp   (step_rsp)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.sck         = rsp_data_ff.sck;
   assign rsp_chan.data_drive  = rsp_data_ff.data_drive;
   assign rsp_chan.data_out    = rsp_data_ff.data_out;
   assign rsp_chan.busy_res    = rsp_data_ff.busy_res;
   assign rsp_chan.done_res    = rsp_data_ff.done_res;
   assign rsp_chan.value       = rsp_data_ff.value;
   assign rsp_chan.checksum    = rsp_data_ff.checksum;
   assign rsp_chan.error_count = rsp_data_ff.error_count;

endmodule
